/* hdl/izh_pkg.sv */
// ----------------------------------------------------------------------------
// izh_pkg
// Shared types, codes and fixed-point helpers for the Izhikevich RK4 neuron
// stepping pipeline.
// ----------------------------------------------------------------------------
package izh_pkg;

    // Data and index widths.
    localparam int DW    = 32;
    localparam int IDX_W = 10;
    localparam int ACC_W = 35;
    localparam int PW    = 68;
    localparam int H_W   = 31;
    localparam int H6_W  = 29;

    // Input action codes.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_STEP_MS   = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;

    // Reset values of the configuration registers and the derived step sizes.
    localparam logic [H_W-1:0]       STEP_MS_RST = 31'd65536;
    localparam logic signed [DW-1:0] THRESH_RST  = 32'sd1966080;
    localparam logic [DW-1:0]        HP3_RST     = 32'd65539;
    localparam logic [H_W-1:0]       HH_RST      = 31'd32768;
    localparam logic [H6_W-1:0]      H6_RST      = 29'd10923;

    // Reciprocal of six for a 32-bit unsigned dividend, used with a shift of 34.
    localparam logic [63:0] RECIP6 = 64'h0000_0000_AAAA_AAAB;

    // Saturation bounds in product width.
    localparam logic signed [PW-1:0] SAT_MAX = PW'(32'sh7FFF_FFFF);
    localparam logic signed [PW-1:0] SAT_MIN = -SAT_MAX - PW'(1);

    // One neuron's context as it moves down the pipeline.
    typedef struct packed {
        logic                    valid;
        logic [IDX_W-1:0]        idx;
        logic signed [DW-1:0]    ic;
        logic signed [DW-1:0]    v0;
        logic signed [DW-1:0]    u0;
        logic signed [DW-1:0]    a;
        logic signed [DW-1:0]    b;
        logic signed [DW-1:0]    c;
        logic signed [DW-1:0]    d;
        logic signed [DW-1:0]    pv;
        logic signed [DW-1:0]    pu;
        logic signed [DW-1:0]    k;
        logic signed [DW-1:0]    l;
        logic signed [ACC_W-1:0] ks;
        logic signed [ACC_W-1:0] ls;
    } ctx_t;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] x);
        logic signed [DW-1:0] r;
        if (x > SAT_MAX)
            r = SAT_MAX[DW-1:0];
        else if (x < SAT_MIN)
            r = SAT_MIN[DW-1:0];
        else
            r = x[DW-1:0];
        return r;
    endfunction

    // Round half up, shift out the fraction bits, then saturate.
    function automatic logic signed [DW-1:0] round_shift(input logic signed [PW-1:0] p,
                                                         input int frac);
        logic signed [PW-1:0] r;
        r = (p + (PW'(1) <<< (frac - 1))) >>> frac;
        return sat32(r);
    endfunction

endpackage

/* hdl/izh_ram.sv */
// ----------------------------------------------------------------------------
// izh_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module izh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/izh_eval.sv */
// ----------------------------------------------------------------------------
// izh_eval
// Four-stage evaluation of the Izhikevich derivatives dv/dt and du/dt at the
// point carried in the context.
// ----------------------------------------------------------------------------
module izh_eval import izh_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  ctx_t             ctx_in,
    input  logic [IDX_W-1:0] query_idx,
    output logic             hit,
    output ctx_t             ctx_out
);

    // Equation constants in the chosen fixed-point format.
    localparam longint ONE      = longint'(1) << FRAC_BITS;
    localparam longint C140_RAW = 140 * ONE;
    localparam longint C140_L   = (C140_RAW > 64'sd2147483647) ? 64'sd2147483647 : C140_RAW;
    localparam logic signed [DW-1:0] C004_Q = DW'(((4 * ONE) + 50) / 100);
    localparam logic signed [DW-1:0] C5_Q   = DW'(5 * ONE);
    localparam logic signed [DW-1:0] C140_Q = DW'(C140_L);

    ctx_t s1_reg, s2_reg, s3_reg, s4_reg, s4_next;
    logic signed [PW-1:0] pa_reg, pa_next, pb_reg, pb_next;
    logic signed [PW-1:0] pc_reg, pc_next, pd_reg, pd_next;
    logic signed [DW-1:0] t1_reg, t1_next, w_reg, w_next;
    logic signed [DW-1:0] t2;

    // Stage 1: 0.04 v and b v.
    always_comb
    begin
        pa_next = PW'(C004_Q) * PW'(ctx_in.pv);
        pb_next = PW'(ctx_in.b) * PW'(ctx_in.pv);
    end

    // Stage 2: add 5 to the first term, form b v - u.
    always_comb
    begin
        t1_next = sat32(PW'(round_shift(pa_reg, FRAC_BITS)) + PW'(C5_Q));
        w_next  = sat32(PW'(round_shift(pb_reg, FRAC_BITS)) - PW'(s1_reg.pu));
    end

    // Stage 3: (0.04 v + 5) v and a (b v - u).
    always_comb
    begin
        pc_next = PW'(t1_reg) * PW'(s2_reg.pv);
        pd_next = PW'(s2_reg.a) * PW'(w_reg);
    end

    // Stage 4: finish both derivatives.
    always_comb
    begin
        t2        = sat32(PW'(round_shift(pc_reg, FRAC_BITS)) + PW'(C140_Q));
        s4_next   = s3_reg;
        s4_next.k = sat32(PW'(t2) - PW'(s3_reg.pu));
        s4_next.l = round_shift(pd_reg, FRAC_BITS);
    end

    // Stage registers, all held while the pipeline is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
        end
        else if (adv)
        begin
            s1_reg <= ctx_in;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            s4_reg <= s4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            t1_reg <= t1_next;
            w_reg  <= w_next;
            pc_reg <= pc_next;
            pd_reg <= pd_next;
        end
    end

    // Report whether a neuron is in flight in any stage here.
    assign hit = (s1_reg.valid && s1_reg.idx == query_idx) ||
                 (s2_reg.valid && s2_reg.idx == query_idx) ||
                 (s3_reg.valid && s3_reg.idx == query_idx) ||
                 (s4_reg.valid && s4_reg.idx == query_idx);

    assign ctx_out = s4_reg;

endmodule

/* hdl/izh_update.sv */
// ----------------------------------------------------------------------------
// izh_update
// Two-stage RK4 point update: next evaluation point from the latest slopes,
// and accumulation of the weighted slope sums.
// ----------------------------------------------------------------------------
module izh_update import izh_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic signed [DW-1:0] hstep,
    input  logic                 dbl,
    input  ctx_t                 ctx_in,
    input  logic [IDX_W-1:0]     query_idx,
    output logic                 hit,
    output ctx_t                 ctx_out
);

    ctx_t u1_reg, u1_next, u2_reg, u2_next;
    logic signed [PW-1:0] q1_reg, q1_next, q2_reg, q2_next;

    // Stage 1: scale slopes by the step and add them into the sums.
    always_comb
    begin
        q1_next    = PW'(hstep) * PW'(ctx_in.k);
        q2_next    = PW'(hstep) * PW'(ctx_in.l);
        u1_next    = ctx_in;
        u1_next.ks = ctx_in.ks + (dbl ? (ACC_W'(ctx_in.k) <<< 1) : ACC_W'(ctx_in.k));
        u1_next.ls = ctx_in.ls + (dbl ? (ACC_W'(ctx_in.l) <<< 1) : ACC_W'(ctx_in.l));
    end

    // Stage 2: new evaluation point from the starting state.
    always_comb
    begin
        u2_next    = u1_reg;
        u2_next.pv = sat32(PW'(u1_reg.v0) + PW'(round_shift(q1_reg, FRAC_BITS)));
        u2_next.pu = sat32(PW'(u1_reg.u0) + PW'(round_shift(q2_reg, FRAC_BITS)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u1_reg <= '0;
            u2_reg <= '0;
        end
        else if (adv)
        begin
            u1_reg <= u1_next;
            u2_reg <= u2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q1_reg <= q1_next;
            q2_reg <= q2_next;
        end
    end

    assign hit = (u1_reg.valid && u1_reg.idx == query_idx) ||
                 (u2_reg.valid && u2_reg.idx == query_idx);

    assign ctx_out = u2_reg;

endmodule

/* hdl/izhikevich_neuron_rk4_step.sv */
// ----------------------------------------------------------------------------
// izhikevich_neuron_rk4_step
// Bank of Izhikevich neurons; each step transaction advances one neuron by one
// classic RK4 step in a fully pipelined datapath.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while the output is not stalled; a step
// or load is held off while a step of the same neuron is in flight, and a load
// also waits in every cycle in which a result is written back to the
// voltage/recovery memory port.
// Reset: asynchronous, clears pipeline valids and the configuration registers
// (step 1.0 ms, threshold 30.0); neuron memories are not cleared.
module izhikevich_neuron_rk4_step import izh_pkg::*; #(
    parameter int NEURONS   = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [DW-1:0]           cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    action,
    input  logic [IDX_W-1:0]        neuron_index,
    input  logic signed [DW-1:0]    input_current,
    input  logic signed [DW-1:0]    load_voltage,
    input  logic signed [DW-1:0]    load_recovery,
    input  logic signed [DW-1:0]    load_a,
    input  logic signed [DW-1:0]    load_b,
    input  logic signed [DW-1:0]    load_c,
    input  logic signed [DW-1:0]    load_d,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [IDX_W-1:0]        neuron_out,
    output logic                    spiked,
    output logic signed [DW-1:0]    voltage_out,
    output logic signed [DW-1:0]    recovery_out
);

    localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int NHIT = 12;

    // Configuration registers and derived step sizes.
    logic [H_W-1:0]       step_ms_reg, step_ms_next;
    logic signed [DW-1:0] thr_reg, thr_next;
    logic [DW-1:0]        hp3_reg, hp3_next;
    logic [H_W-1:0]       hh_reg, hh_next;
    logic [H6_W-1:0]      h6_reg, h6_next;
    logic [63:0]          h6_prod;

    // Handshake and memory control.
    logic adv, in_range, acc, load_we, step_acc, wb_now;
    logic [NHIT-1:0] hit_vec;
    logic [AW-1:0]   in_addr, vu_waddr;
    logic [2*DW-1:0] vu_wdata, vu_rdata;
    logic [4*DW-1:0] par_rdata;
    logic            vu_we;

    // Pipeline contexts.
    ctx_t rd_reg, rd_next, e1_in;
    ctx_t e1_out, u1_out, e2_out, u2_out, e3_out, u3_out, e4_out;
    ctx_t f1_reg, f1_next, f2_reg, f3_reg, f3_next, f4_reg, f4_next;
    logic signed [PW-1:0] pvp_reg, pvp_next, pup_reg, pup_next;
    logic                 f4_spike_reg, f4_spike_next;
    logic signed [DW-1:0] f4_uinc_reg, f4_uinc_next;
    logic signed [DW-1:0] wb_v, wb_u;

    // Output register.
    logic                 out_valid_reg;
    logic [IDX_W-1:0]     neuron_out_reg;
    logic                 spiked_reg;
    logic signed [DW-1:0] voltage_out_reg, recovery_out_reg;

    // Configuration writes.
    always_comb
    begin
        step_ms_next = step_ms_reg;
        thr_next     = thr_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEP_MS:   step_ms_next = cfg_data[H_W-1:0];
                REG_THRESHOLD: thr_next     = $signed(cfg_data);
                default:       ;
            endcase
        end
    end

    // Half step registered from the step size; one-sixth step registered from the registered step plus three.
    always_comb
    begin
        hp3_next = DW'(step_ms_reg) + DW'(3);
        hh_next  = H_W'((DW'(step_ms_reg) + DW'(1)) >> 1);
        h6_prod  = 64'(hp3_reg) * RECIP6;
        h6_next  = h6_prod[34 +: H6_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ms_reg <= STEP_MS_RST;
            thr_reg     <= THRESH_RST;
            hp3_reg     <= HP3_RST;
            hh_reg      <= HH_RST;
            h6_reg      <= H6_RST;
        end
        else
        begin
            step_ms_reg <= step_ms_next;
            thr_reg     <= thr_next;
            hp3_reg     <= hp3_next;
            hh_reg      <= hh_next;
            h6_reg      <= h6_next;
        end
    end

    // Input handshake: hold off a neuron already in flight, and a load that
    // meets a write-back on the shared memory port.
    assign adv      = !out_valid_reg || !out_stall;
    assign wb_now   = adv && f4_reg.valid;
    assign in_range = (32'(neuron_index) < 32'(NEURONS));
    assign in_stall = !adv || (|hit_vec) || ((action == ACT_LOAD) && wb_now);
    assign acc      = in_valid && !in_stall;
    assign load_we  = acc && (action == ACT_LOAD) && in_range;
    assign step_acc = acc && (action == ACT_STEP) && in_range;
    assign in_addr  = AW'(neuron_index);

    // Voltage and recovery memory: written by loads and by results.
    assign vu_we    = load_we || wb_now;
    assign vu_waddr = wb_now ? AW'(f4_reg.idx) : in_addr;
    assign vu_wdata = wb_now ? {wb_v, wb_u} : {load_voltage, load_recovery};

    izh_ram #(
        .WIDTH (2 * DW),
        .DEPTH (NEURONS)
    ) u_vu_ram (
        .clk   (clk),
        .we    (vu_we),
        .waddr (vu_waddr),
        .wdata (vu_wdata),
        .re    (adv),
        .raddr (in_addr),
        .rdata (vu_rdata)
    );

    // Parameter memory: a, b, c, d, written by loads only.
    izh_ram #(
        .WIDTH (4 * DW),
        .DEPTH (NEURONS)
    ) u_par_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (in_addr),
        .wdata ({load_a, load_b, load_c, load_d}),
        .re    (adv),
        .raddr (in_addr),
        .rdata (par_rdata)
    );

    // Read stage: tag, index and input current wait for the memory data.
    always_comb
    begin
        rd_next       = '0;
        rd_next.valid = step_acc;
        rd_next.idx   = neuron_index;
        rd_next.ic    = input_current;
    end

    always_comb
    begin
        e1_in    = rd_reg;
        e1_in.v0 = $signed(vu_rdata[2*DW-1:DW]);
        e1_in.u0 = $signed(vu_rdata[DW-1:0]);
        e1_in.a  = $signed(par_rdata[4*DW-1:3*DW]);
        e1_in.b  = $signed(par_rdata[3*DW-1:2*DW]);
        e1_in.c  = $signed(par_rdata[2*DW-1:DW]);
        e1_in.d  = $signed(par_rdata[DW-1:0]);
        e1_in.pv = e1_in.v0;
        e1_in.pu = e1_in.u0;
        e1_in.ks = '0;
        e1_in.ls = '0;
    end

    // RK4 chain: four evaluations with three point updates between them.
    izh_eval #(.FRAC_BITS(FRAC_BITS)) u_eval1 (
        .clk(clk), .rst_n(rst_n), .adv(adv), .ctx_in(e1_in),
        .query_idx(neuron_index), .hit(hit_vec[0]), .ctx_out(e1_out)
    );

    izh_update #(.FRAC_BITS(FRAC_BITS)) u_upd1 (
        .clk(clk), .rst_n(rst_n), .adv(adv), .hstep($signed({1'b0, hh_reg})), .dbl(1'b0),
        .ctx_in(e1_out), .query_idx(neuron_index), .hit(hit_vec[1]), .ctx_out(u1_out)
    );

    izh_eval #(.FRAC_BITS(FRAC_BITS)) u_eval2 (
        .clk(clk), .rst_n(rst_n), .adv(adv), .ctx_in(u1_out),
        .query_idx(neuron_index), .hit(hit_vec[2]), .ctx_out(e2_out)
    );

    izh_update #(.FRAC_BITS(FRAC_BITS)) u_upd2 (
        .clk(clk), .rst_n(rst_n), .adv(adv), .hstep($signed({1'b0, hh_reg})), .dbl(1'b1),
        .ctx_in(e2_out), .query_idx(neuron_index), .hit(hit_vec[3]), .ctx_out(u2_out)
    );

    izh_eval #(.FRAC_BITS(FRAC_BITS)) u_eval3 (
        .clk(clk), .rst_n(rst_n), .adv(adv), .ctx_in(u2_out),
        .query_idx(neuron_index), .hit(hit_vec[4]), .ctx_out(e3_out)
    );

    izh_update #(.FRAC_BITS(FRAC_BITS)) u_upd3 (
        .clk(clk), .rst_n(rst_n), .adv(adv), .hstep($signed({1'b0, step_ms_reg})),
        .dbl(1'b1), .ctx_in(e3_out), .query_idx(neuron_index), .hit(hit_vec[5]),
        .ctx_out(u3_out)
    );

    izh_eval #(.FRAC_BITS(FRAC_BITS)) u_eval4 (
        .clk(clk), .rst_n(rst_n), .adv(adv), .ctx_in(u3_out),
        .query_idx(neuron_index), .hit(hit_vec[6]), .ctx_out(e4_out)
    );

    // Final 1: add the last slopes into the weighted sums.
    always_comb
    begin
        f1_next    = e4_out;
        f1_next.ks = e4_out.ks + ACC_W'(e4_out.k);
        f1_next.ls = e4_out.ls + ACC_W'(e4_out.l);
    end

    // Final 2: scale the sums by one sixth of the step.
    always_comb
    begin
        pvp_next = PW'(f1_reg.ks) * PW'($signed({1'b0, h6_reg}));
        pup_next = PW'(f1_reg.ls) * PW'($signed({1'b0, h6_reg}));
    end

    // Final 3: integrated state.
    always_comb
    begin
        f3_next    = f2_reg;
        f3_next.pv = sat32(PW'(f2_reg.v0) + PW'(round_shift(pvp_reg, FRAC_BITS)));
        f3_next.pu = sat32(PW'(f2_reg.u0) + PW'(round_shift(pup_reg, FRAC_BITS)));
    end

    // Final 4: input current, spike test and post-spike recovery.
    always_comb
    begin
        f4_next       = f3_reg;
        f4_next.pv    = sat32(PW'(f3_reg.pv) + PW'(f3_reg.ic));
        f4_spike_next = (f4_next.pv >= thr_reg);
        f4_uinc_next  = sat32(PW'(f3_reg.pu) + PW'(f3_reg.d));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            f1_reg <= '0;
            f2_reg <= '0;
            f3_reg <= '0;
            f4_reg <= '0;
        end
        else if (adv)
        begin
            rd_reg <= rd_next;
            f1_reg <= f1_next;
            f2_reg <= f1_reg;
            f3_reg <= f3_next;
            f4_reg <= f4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pvp_reg      <= pvp_next;
            pup_reg      <= pup_next;
            f4_spike_reg <= f4_spike_next;
            f4_uinc_reg  <= f4_uinc_next;
        end
    end

    // Result after any spike reset; also written back to memory.
    assign wb_v = f4_spike_reg ? f4_reg.c : f4_reg.pv;
    assign wb_u = f4_spike_reg ? f4_uinc_reg : f4_reg.pu;

    // In-flight neurons outside the evaluation and update modules.
    assign hit_vec[7]  = rd_reg.valid && (rd_reg.idx == neuron_index);
    assign hit_vec[8]  = f1_reg.valid && (f1_reg.idx == neuron_index);
    assign hit_vec[9]  = f2_reg.valid && (f2_reg.idx == neuron_index);
    assign hit_vec[10] = f3_reg.valid && (f3_reg.idx == neuron_index);
    assign hit_vec[11] = f4_reg.valid && (f4_reg.idx == neuron_index);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= f4_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neuron_out_reg   <= f4_reg.idx;
            spiked_reg       <= f4_spike_reg;
            voltage_out_reg  <= wb_v;
            recovery_out_reg <= wb_u;
        end
    end

    assign out_valid    = out_valid_reg;
    assign neuron_out   = neuron_out_reg;
    assign spiked       = spiked_reg;
    assign voltage_out  = voltage_out_reg;
    assign recovery_out = recovery_out_reg;

    // A load never shares the memory write port with a result write-back.
    assert property (@(posedge clk) disable iff (!rst_n) !(load_we && wb_now))
        else $error("load collided with result write-back");

    // An accepted in-range step enters the read stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) step_acc |=> rd_reg.valid)
        else $error("accepted step did not enter the pipeline");

    // A result without a spike lies below the threshold.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !spiked) |-> (voltage_out < thr_reg))
        else $error("non-spiking result at or above threshold");

endmodule
